### hdl/assert_macros.svh
// assertion macros used by the collector unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define SCC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression that must never be true outside reset
`define SCC_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SCC_ASSERT(lbl, clk, rst, prop, msg)
`define SCC_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### hdl/scc_pkg.sv
// shared types and constants of the semispace copying collector
package scc_pkg;
   localparam int MEM_WORDS_DEF = 4096;
   localparam logic [7:0] FWD_TAG = 8'hFF;
   localparam logic [31:0] SIZE_MASK = 32'h00FF_FFFF;
   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;
   localparam logic [1:0] ROOTS_DONE = 2'd3;

   typedef enum logic [4:0] {
      S_CLR, S_CFG, S_IDLE, S_WR, S_RD, S_RD2, S_ALLOC, S_MK_RD, S_MK_WR,
      S_ROOT, S_RL_HDR, S_RL_CHK, S_RL_FWD, S_CP_RD, S_CP_WR, S_RL_RET,
      S_SC_TOP, S_SC_HDR, S_SC_FLD, S_SC_V, S_SC_BIT, S_SWAP, S_SWAP2, S_DONE
   } state_type;
endpackage

### hdl/scc_req_if.sv
// request channel: one allocate, write or read word
interface scc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  tag;
   logic [11:0] size;
   logic [13:0] addr;
   logic [31:0] data;
   logic [13:0] root_a;
   logic [13:0] root_b;
   logic [13:0] root_c;
   modport source (output valid, mode, tag, size, addr, data, root_a, root_b, root_c,
                   input ready);
   modport sink (input valid, mode, tag, size, addr, data, root_a, root_b, root_c,
                 output ready);
endinterface

### hdl/scc_rsp_if.sv
// response channel: one result word per request
interface scc_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [13:0] block_addr;
   logic [31:0] read_data;
   logic [13:0] root_a_new;
   logic [13:0] root_b_new;
   logic [13:0] root_c_new;
   logic        collected;
   modport source (output valid, status, block_addr, read_data, root_a_new, root_b_new,
                   root_c_new, collected, input ready);
   modport sink (input valid, status, block_addr, read_data, root_a_new, root_b_new,
                 root_c_new, collected, output ready);
endinterface

### hdl/semispace_copying_collector_unit.sv
// semispace copying collector: bump allocator with cheney collection over one word ram
//
// req_ch carries one word: allocate (mode 0), write word (mode 1) or read word (mode 2).
// rsp_ch returns exactly one word per request, in order. csr_we/csr_wdata set the heap
// base; a write resets allocation to the lower half and clears its bitmap, one word a cycle,
// while no request is taken.
// All state sits in one single-port ram of MEM_WORDS words with a registered read port,
// so every access takes its own cycle and one request is worked on at a time.
// The next request is taken once the response is loaded into the output register.
// An allocation that does not fit runs a collection: the target half is cleared,
// each live block reached from a root is forwarded and copied, each scanned block
// header sets up its fields and each scanned field copies the block it points at,
// then the old half is cleared and the allocation retried.
// After reset the whole ram is cleared before the first request.
// A finished response waits in the output register while rsp_ch.ready is low; the next
// request is still accepted, and its response waits until the register frees up.
module semispace_copying_collector_unit #(
   parameter int MEM_WORDS = scc_pkg::MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   scc_req_if.sink     req_ch,
   scc_rsp_if.source   rsp_ch
);
   import scc_pkg::*;
   `include "assert_macros.svh"

   localparam int AW = $clog2(MEM_WORDS);
   localparam int PW = ((AW > 11) ? AW : 11) + 2;
   localparam int SCW = ((PW > 24) ? PW : 24) + 2;
   localparam int XW = ((PW + 2) > 24) ? (PW + 2) : 24;
   localparam int CW = (PW > 24) ? PW : 24;
   localparam int FP_RST = (MEM_WORDS / 2) / 32 + 1;

   // half membership and bitmap position of a word index
   function automatic logic in_half(input logic [29:0] p, input logic [PW-1:0] base,
                                    input logic [PW-1:0] r, input logic [PW-1:0] b);
      logic [30:0] lo, hi;
      lo = 31'(base) + 31'(b);
      hi = 31'(base) + 31'(r);
      return ({1'b0, p} >= lo) && ({1'b0, p} < hi);
   endfunction

   function automatic logic [29:0] map_off(input logic [29:0] p, input logic [PW-1:0] base,
                                           input logic [PW-1:0] b);
      return p - 30'(base) - 30'(b);
   endfunction

   state_type state_ff, state_in, clr_ret_ff;
   logic [PW-1:0] clr_ptr_ff, clr_end_ff, fp_ff, fr_ff, src_ff, mk_p_ff, mk_base_ff, sv_p_ff;
   logic [10:0] hs_ff;
   logic half_ff, cfg_pend_ff, retry_ff, mk_alloc_ff, from_field_ff;
   logic [1:0] mode_ff, idx_ff;
   logic [7:0] tag_ff;
   logic [11:0] size_ff, waddr_ff;
   logic [31:0] data_ff, hdr_ff, rdata_ff;
   logic [13:0] root_ff [3];
   logic [23:0] na_ff, cnt_ff;
   logic [SCW-1:0] scan_ff, fld_ff, fld_end_ff;
   logic [4:0] sv_bit_ff;
   logic status_ff, coll_ff;
   logic [13:0] baddr_ff;

   // response register
   logic rsp_valid_ff, rsp_status_ff, rsp_coll_ff;
   logic [13:0] rsp_baddr_ff, rsp_ra_ff, rsp_rb_ff, rsp_rc_ff;
   logic [31:0] rsp_rdata_ff;

   // ram port
   logic [31:0] ram [MEM_WORDS];
   logic [31:0] ram_q_ff, mem_q, mem_wd;
   logic ram_oob_ff, mem_we;
   logic [PW-1:0] mem_addr;

   // geometry of the halves
   logic [PW-1:0] mw_p, hs_p, r_len, b_len, fb, tb, end_t, fr_n, room, rp;
   logic [PW:0] fit_lhs, fit_rhs;
   logic fits, root_in, mk_in, v_in, out_free, accept;
   logic [29:0] mk_off, sv_off, pv;
   logic [XW-1:0] nax;

   assign mw_p = PW'(MEM_WORDS);
   assign hs_p = PW'(hs_ff);
   assign r_len = (hs_p < mw_p) ? ((mw_p - hs_p) >> 1) : '0;
   assign b_len = (r_len >> 5) + PW'(1);
   assign fb = hs_p + (half_ff ? r_len : '0);
   assign tb = hs_p + (half_ff ? '0 : r_len);
   assign end_t = tb + r_len;
   assign mem_q = ram_oob_ff ? 32'd0 : ram_q_ff;
   assign fit_lhs = (PW+1)'(fp_ff) + (PW+1)'(size_ff) + (PW+1)'(1);
   assign fit_rhs = (PW+1)'(fb) + (PW+1)'(r_len);
   assign fits = fit_lhs < fit_rhs;
   assign rp = (idx_ff != ROOTS_DONE) ? PW'(root_ff[idx_ff][13:2]) : '0;
   assign root_in = (idx_ff != ROOTS_DONE) && in_half(30'(rp), fb, r_len, b_len);
   assign mk_in = in_half(30'(mk_p_ff), mk_base_ff, r_len, b_len);
   assign mk_off = map_off(30'(mk_p_ff), mk_base_ff, b_len);
   assign pv = mem_q[31:2];
   assign v_in = in_half(pv, fb, r_len, b_len);
   assign sv_off = map_off(pv, fb, b_len);
   assign fr_n = fr_ff + ((fr_ff < end_t) ? PW'(1) : '0);
   assign nax = XW'(fr_n) << 2;
   assign room = end_t - fr_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && !cfg_pend_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:    state_in = (clr_ptr_ff < clr_end_ff) ? S_CLR : clr_ret_ff;
         S_CFG:    state_in = S_CLR;
         S_IDLE: begin
            if (cfg_pend_ff) state_in = S_CFG;
            else if (accept) begin
               unique case (req_ch.mode)
                  MODE_ALLOC: state_in = S_ALLOC;
                  MODE_WRITE: state_in = S_WR;
                  MODE_READ:  state_in = S_RD;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_WR:     state_in = S_DONE;
         S_RD:     state_in = S_RD2;
         S_RD2:    state_in = S_DONE;
         S_ALLOC:  state_in = fits ? S_MK_RD : (retry_ff ? S_DONE : S_CLR);
         S_MK_RD:  state_in = mk_in ? S_MK_WR : (mk_alloc_ff ? S_DONE : S_RL_FWD);
         S_MK_WR:  state_in = mk_alloc_ff ? S_DONE : S_RL_FWD;
         S_ROOT:   state_in = (idx_ff == ROOTS_DONE) ? S_SWAP : (root_in ? S_RL_HDR : S_ROOT);
         S_RL_HDR: state_in = S_RL_CHK;
         S_RL_CHK: state_in = (mem_q[7:0] == FWD_TAG) ? S_RL_RET : S_MK_RD;
         S_RL_FWD: state_in = S_CP_RD;
         S_CP_RD:  state_in = (cnt_ff == '0) ? S_RL_RET : S_CP_WR;
         S_CP_WR:  state_in = S_CP_RD;
         S_RL_RET: state_in = from_field_ff ? S_SC_FLD : S_SC_TOP;
         S_SC_TOP: state_in = (scan_ff < SCW'(fr_ff)) ? S_SC_HDR : S_ROOT;
         S_SC_HDR: state_in = S_SC_FLD;
         S_SC_FLD: state_in = ((fld_ff < fld_end_ff) && (fld_ff < SCW'(end_t))) ?
                              S_SC_V : S_SC_TOP;
         S_SC_V:   state_in = v_in ? S_SC_BIT : S_SC_FLD;
         S_SC_BIT: state_in = mem_q[sv_bit_ff] ? S_RL_HDR : S_SC_FLD;
         S_SWAP:   state_in = S_CLR;
         S_SWAP2:  state_in = S_ALLOC;
         S_DONE:   state_in = out_free ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // ram port drive
   always_comb begin
      mem_addr = '0;
      mem_we = 1'b0;
      mem_wd = '0;
      unique case (state_ff)
         S_CLR: begin
            mem_addr = clr_ptr_ff;
            mem_we = clr_ptr_ff < clr_end_ff;
         end
         S_WR: begin
            mem_addr = PW'(waddr_ff);
            mem_we = 1'b1;
            mem_wd = data_ff;
         end
         S_RD:     mem_addr = PW'(waddr_ff);
         S_ALLOC: begin
            mem_addr = fp_ff;
            mem_we = fits;
            mem_wd = 32'({size_ff, tag_ff});
         end
         S_MK_RD:  mem_addr = mk_base_ff + PW'(mk_off >> 5);
         S_MK_WR: begin
            mem_addr = mk_base_ff + PW'(mk_off >> 5);
            mem_we = 1'b1;
            mem_wd = mem_q | (32'd1 << mk_off[4:0]);
         end
         S_RL_HDR: mem_addr = src_ff - PW'(1);
         S_RL_CHK: begin
            mem_addr = fr_ff;
            mem_we = (mem_q[7:0] != FWD_TAG) && (fr_ff < end_t);
            mem_wd = mem_q;
         end
         S_RL_FWD: begin
            mem_addr = src_ff - PW'(1);
            mem_we = 1'b1;
            mem_wd = {na_ff, FWD_TAG};
         end
         S_CP_RD:  mem_addr = src_ff;
         S_CP_WR: begin
            mem_addr = fr_ff;
            mem_we = 1'b1;
            mem_wd = mem_q;
         end
         S_RL_RET: begin
            mem_addr = fld_ff[PW-1:0];
            mem_we = from_field_ff;
            mem_wd = 32'(na_ff);
         end
         S_SC_TOP: mem_addr = scan_ff[PW-1:0];
         S_SC_FLD: mem_addr = fld_ff[PW-1:0];
         S_SC_V:   mem_addr = fb + PW'(sv_off >> 5);
         default: begin
            mem_addr = '0;
         end
      endcase
   end

   // word ram, one access per cycle
   always_ff @(posedge clock) begin
      if (mem_we && (mem_addr < mw_p)) ram[mem_addr[AW-1:0]] <= mem_wd;
      ram_q_ff <= ram[mem_addr[AW-1:0]];
      ram_oob_ff <= mem_addr >= mw_p;
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ptr_ff <= '0;
         clr_end_ff <= PW'(MEM_WORDS);
         clr_ret_ff <= S_IDLE;
         hs_ff <= '0;
         half_ff <= 1'b0;
         fp_ff <= PW'(FP_RST);
         cfg_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff <= ROOTS_DONE;
         retry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // output register fills when a response is done, empties when taken
         if ((state_ff == S_DONE) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLR: if (clr_ptr_ff < clr_end_ff) clr_ptr_ff <= clr_ptr_ff + PW'(1);
            S_CFG: begin
               clr_ptr_ff <= hs_p;
               clr_end_ff <= hs_p + b_len;
               clr_ret_ff <= S_IDLE;
               fp_ff <= hs_p + b_len;
               cfg_pend_ff <= 1'b0;
            end
            S_IDLE: if (accept && !cfg_pend_ff) begin
               mode_ff <= req_ch.mode;
               tag_ff <= req_ch.tag;
               size_ff <= req_ch.size;
               waddr_ff <= 12'(req_ch.addr[13:2]);
               data_ff <= req_ch.data;
               root_ff[0] <= req_ch.root_a;
               root_ff[1] <= req_ch.root_b;
               root_ff[2] <= req_ch.root_c;
               status_ff <= 1'b0;
               coll_ff <= 1'b0;
               retry_ff <= 1'b0;
               rdata_ff <= '0;
               baddr_ff <= '0;
            end
            S_RD2: rdata_ff <= mem_q;
            S_ALLOC: begin
               if (fits) begin
                  fp_ff <= PW'(fit_lhs);
                  baddr_ff <= {12'(fp_ff + PW'(1)), 2'b00};
                  mk_p_ff <= fp_ff + PW'(1);
                  mk_base_ff <= fb;
                  mk_alloc_ff <= 1'b1;
               end else if (retry_ff) begin
                  status_ff <= 1'b1;
               end else begin
                  coll_ff <= 1'b1;
                  clr_ptr_ff <= tb;
                  clr_end_ff <= end_t;
                  clr_ret_ff <= S_ROOT;
                  idx_ff <= '0;
                  fr_ff <= tb + b_len;
               end
            end
            S_ROOT: if (idx_ff != ROOTS_DONE) begin
               if (root_in) begin
                  scan_ff <= SCW'(fr_ff);
                  src_ff <= rp;
                  from_field_ff <= 1'b0;
               end else begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            S_RL_CHK: begin
               hdr_ff <= mem_q;
               if (mem_q[7:0] == FWD_TAG) begin
                  na_ff <= mem_q[31:8];
               end else begin
                  fr_ff <= fr_n;
                  mk_p_ff <= fr_n;
                  mk_base_ff <= tb;
                  mk_alloc_ff <= 1'b0;
                  na_ff <= nax[23:0];
               end
            end
            S_RL_FWD: cnt_ff <= (CW'(hdr_ff[31:8]) > CW'(room)) ? 24'(room) : hdr_ff[31:8];
            S_CP_WR: begin
               fr_ff <= fr_ff + PW'(1);
               src_ff <= src_ff + PW'(1);
               cnt_ff <= cnt_ff - 24'd1;
            end
            S_RL_RET: begin
               if (from_field_ff) fld_ff <= fld_ff + SCW'(1);
               else if (idx_ff != ROOTS_DONE) root_ff[idx_ff] <= na_ff[13:0];
            end
            S_SC_TOP: if (!(scan_ff < SCW'(fr_ff))) idx_ff <= idx_ff + 2'd1;
            S_SC_HDR: begin
               fld_ff <= scan_ff + SCW'(1);
               fld_end_ff <= scan_ff + SCW'(1) + SCW'(mem_q[31:8]);
               scan_ff <= scan_ff + SCW'(1) + SCW'(mem_q[31:8]);
            end
            S_SC_V: begin
               if (v_in) begin
                  sv_bit_ff <= sv_off[4:0];
                  sv_p_ff <= pv[PW-1:0];
               end else begin
                  fld_ff <= fld_ff + SCW'(1);
               end
            end
            S_SC_BIT: begin
               if (mem_q[sv_bit_ff]) begin
                  src_ff <= sv_p_ff;
                  from_field_ff <= 1'b1;
               end else begin
                  fld_ff <= fld_ff + SCW'(1);
               end
            end
            S_SWAP: begin
               clr_ptr_ff <= fb;
               clr_end_ff <= fb + r_len;
               clr_ret_ff <= S_SWAP2;
            end
            S_SWAP2: begin
               half_ff <= ~half_ff;
               fp_ff <= fr_ff;
               retry_ff <= 1'b1;
            end
            S_DONE: if (out_free) begin
               rsp_status_ff <= status_ff;
               rsp_baddr_ff <= status_ff ? 14'd0 : baddr_ff;
               rsp_rdata_ff <= rdata_ff;
               rsp_ra_ff <= root_ff[0];
               rsp_rb_ff <= root_ff[1];
               rsp_rc_ff <= root_ff[2];
               rsp_coll_ff <= coll_ff;
            end
            default: begin
            end
         endcase
         // configuration write restarts allocation in the lower half
         if (csr_we) begin
            hs_ff <= csr_wdata;
            half_ff <= 1'b0;
            cfg_pend_ff <= 1'b1;
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.block_addr = rsp_baddr_ff;
   assign rsp_ch.read_data = rsp_rdata_ff;
   assign rsp_ch.root_a_new = rsp_ra_ff;
   assign rsp_ch.root_b_new = rsp_rb_ff;
   assign rsp_ch.root_c_new = rsp_rc_ff;
   assign rsp_ch.collected = rsp_coll_ff;

   // checks
   `SCC_ASSERT(a_accept_leaves_idle, clock, reset, accept |=> (state_ff != S_IDLE), "accept stayed idle")
   `SCC_NEVER(a_no_write_idle, clock, reset, (state_ff == S_IDLE) && mem_we, "ram write while idle")
   `SCC_ASSERT(a_fp_in_half, clock, reset, ((state_ff == S_DONE) && (mode_ff == MODE_ALLOC) && !status_ff) |-> ((PW+1)'(fp_ff) < fit_rhs), "free pointer left half")
endmodule
